@@ rtl/stmc_pkg.sv @@
// Shared types, register indexes and constants of the solar tracker mode controller.
`timescale 1ns / 1ps

package stmc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OVERHEAT_TEMP   = 3'd0,
        CFG_TARGET_MV       = 3'd1,
        CFG_HYSTERESIS_BAND = 3'd2,
        CFG_REPORT_PERIOD   = 3'd3,
        CFG_SEARCH_PERIOD   = 3'd4,
        CFG_PWM_STEP        = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_REGULATE = 2'd0,
        MODE_REPORT   = 2'd1,
        MODE_SCAN     = 2'd2,
        MODE_HOT      = 2'd3
    } mode_t;

    localparam logic [7:0] SCAN_STEP  = 8'd15;
    localparam logic [7:0] SCAN_END   = 8'd180;
    localparam logic [7:0] FLIP_LIMIT = 8'd90;
    localparam logic [7:0] FAR_ANGLE  = 8'd180;
    localparam logic [7:0] DUTY_MAX   = 8'd255;

    localparam logic [7:0]  RST_OVERHEAT_TEMP   = 8'd60;
    localparam logic [13:0] RST_TARGET_MV       = 14'd5000;
    localparam logic [10:0] RST_HYSTERESIS_BAND = 11'd200;
    localparam logic [11:0] RST_REPORT_PERIOD   = 12'd61;
    localparam logic [11:0] RST_SEARCH_PERIOD   = 12'd3700;
    localparam logic [6:0]  RST_PWM_STEP        = 7'd10;

    typedef struct packed {
        logic        kind;
        logic [13:0] panel_mv;
        logic [7:0]  temp_c;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  servo_angle;
        logic [7:0]  pwm_duty;
        logic        report_valid;
        logic [13:0] report_mv;
        logic [7:0]  report_temp;
        logic        overheat_alarm;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  overheat_temp;
        logic [13:0] target_mv;
        logic [10:0] hysteresis_band;
        logic [11:0] report_period;
        logic [11:0] search_period;
        logic [6:0]  pwm_step;
    } cfg_t;

    typedef struct packed {
        logic [11:0] tick_count;
        logic [11:0] report_count;
        mode_t       mode;
        logic [7:0]  duty;
        logic [7:0]  angle;
        logic [13:0] stored_mv;
        logic [7:0]  stored_temp;
        logic        scan_active;
        logic [7:0]  scan_angle;
        logic [13:0] best_mv;
        logic [7:0]  best_angle;
        logic        cooling;
    } state_t;

endpackage

@@ rtl/stmc_step.sv @@
// Next-state and result logic for one tick or measurement item.
`timescale 1ns / 1ps

module stmc_step (
    input  stmc_pkg::state_t   st,
    input  stmc_pkg::cfg_t     cfg,
    input  stmc_pkg::in_item_t item,
    output stmc_pkg::state_t   st_next,
    output stmc_pkg::out_item_t res
);
    import stmc_pkg::*;

    logic [11:0]        tick_inc;
    logic [11:0]        rep_inc;
    logic               rep_hit;
    logic               srch_hit;
    logic               hot;
    logic signed [15:0] band_lo;
    logic signed [15:0] mv_s;
    logic [14:0]        band_hi;
    logic [7:0]         duty_dn;
    logic [8:0]         duty_sum;
    logic [7:0]         duty_up;
    logic               new_best;
    logic [7:0]         best_angle_upd;
    logic [7:0]         scan_angle_inc;

    assign tick_inc = st.tick_count + 12'd1;
    assign rep_inc  = st.report_count + 12'd1;
    assign rep_hit  = rep_inc >= cfg.report_period;
    assign srch_hit = tick_inc > cfg.search_period;
    assign hot      = item.temp_c > cfg.overheat_temp;

    assign band_lo  = $signed({2'b00, cfg.target_mv}) - $signed({5'b0, cfg.hysteresis_band});
    assign mv_s     = $signed({2'b00, item.panel_mv});
    assign band_hi  = {1'b0, cfg.target_mv} + {4'b0, cfg.hysteresis_band};

    // saturate at both ends of the duty range
    assign duty_dn  = (st.duty > {1'b0, cfg.pwm_step}) ? st.duty - {1'b0, cfg.pwm_step} : 8'd0;
    assign duty_sum = {1'b0, st.duty} + {2'b00, cfg.pwm_step};
    assign duty_up  = (duty_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_sum[7:0];

    assign new_best       = item.panel_mv > st.best_mv;
    assign best_angle_upd = new_best ? st.scan_angle : st.best_angle;
    assign scan_angle_inc = st.scan_angle + SCAN_STEP;

    always_comb begin
        st_next            = st;
        res.report_valid   = 1'b0;
        res.report_mv      = '0;
        res.report_temp    = '0;
        res.overheat_alarm = 1'b0;

        if (!item.kind) begin
            if (!st.cooling) begin
                st_next.tick_count   = srch_hit ? 12'd0 : tick_inc;
                st_next.report_count = (rep_hit || srch_hit) ? 12'd0 : rep_inc;
                if (!st.scan_active) begin
                    if (srch_hit) begin
                        st_next.mode = MODE_SCAN;
                    end else if (rep_hit) begin
                        st_next.mode = MODE_REPORT;
                    end
                end
            end
        end else begin
            st_next.stored_temp = item.temp_c;
            if (st.cooling || st.mode == MODE_HOT) begin
                if (hot) begin
                    st_next.cooling    = 1'b1;
                    res.overheat_alarm = 1'b1;
                end else begin
                    st_next.cooling = 1'b0;
                    st_next.mode    = MODE_SCAN;
                end
            end else if (hot) begin
                st_next.angle       = (st.angle > FLIP_LIMIT) ? 8'd0 : FAR_ANGLE;
                st_next.scan_active = 1'b0;
                st_next.cooling     = 1'b1;
                st_next.mode        = MODE_HOT;
                res.overheat_alarm  = 1'b1;
            end else begin
                case (st.mode)
                    MODE_REPORT: begin
                        res.report_valid = 1'b1;
                        res.report_mv    = st.stored_mv;
                        res.report_temp  = item.temp_c;
                        st_next.mode     = MODE_REGULATE;
                    end
                    MODE_SCAN: begin
                        if (!st.scan_active) begin
                            st_next.duty        = 8'd0;
                            st_next.scan_active = 1'b1;
                            st_next.scan_angle  = 8'd0;
                            st_next.best_mv     = '0;
                            st_next.best_angle  = st.angle;
                        end else begin
                            if (new_best) begin
                                st_next.best_mv = item.panel_mv;
                            end
                            st_next.best_angle = best_angle_upd;
                            st_next.scan_angle = scan_angle_inc;
                            if (scan_angle_inc >= SCAN_END) begin
                                st_next.scan_active = 1'b0;
                                st_next.scan_angle  = 8'd0;
                                st_next.angle       = best_angle_upd;
                                st_next.mode        = MODE_REGULATE;
                            end
                        end
                    end
                    default: begin
                        st_next.stored_mv = item.panel_mv;
                        if (mv_s < band_lo && st.duty != 8'd0) begin
                            st_next.duty = duty_dn;
                        end else if ({1'b0, item.panel_mv} > band_hi && st.duty != DUTY_MAX) begin
                            st_next.duty = duty_up;
                        end
                    end
                endcase
            end
        end

        res.mode        = st_next.mode;
        res.servo_angle = st_next.scan_active ? st_next.scan_angle : st_next.angle;
        res.pwm_duty    = st_next.duty;
    end

endmodule

@@ rtl/solar_tracker_mode_controller_core.sv @@
// Top level of the solar tracker mode controller: config registers, state and output register.
`timescale 1ns / 1ps
// The result of an accepted item is held in the output register from the next cycle on.
// Throughput: one item per cycle while the output register is not stalled by m_ready.
// An item is taken while the output register is empty or its result is being taken.
// Reset (aresetn low, synchronous) clears all tracker state, empties the output
// register and loads the configuration registers with their default values.

module solar_tracker_mode_controller_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [stmc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [stmc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  stmc_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output stmc_pkg::out_item_t                   m_data
);
    import stmc_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    state_t    state_reg;
    state_t    state_next;
    out_item_t res_reg;
    out_item_t res_next;
    logic      m_valid_reg;
    logic      s_accept;

    // Take a new item while the result slot is empty or frees up in this same cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = res_reg;

    // Decode register writes; unknown indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_OVERHEAT_TEMP:   cfg_next.overheat_temp   = cfg_data[7:0];
                CFG_TARGET_MV:       cfg_next.target_mv       = cfg_data[13:0];
                CFG_HYSTERESIS_BAND: cfg_next.hysteresis_band = cfg_data[10:0];
                CFG_REPORT_PERIOD:   cfg_next.report_period   = cfg_data[11:0];
                CFG_SEARCH_PERIOD:   cfg_next.search_period   = cfg_data[11:0];
                CFG_PWM_STEP:        cfg_next.pwm_step        = cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // All mode, counter, scan and pwm decisions for one item.
    stmc_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (s_data),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.overheat_temp   <= RST_OVERHEAT_TEMP;
            cfg_reg.target_mv       <= RST_TARGET_MV;
            cfg_reg.hysteresis_band <= RST_HYSTERESIS_BAND;
            cfg_reg.report_period   <= RST_REPORT_PERIOD;
            cfg_reg.search_period   <= RST_SEARCH_PERIOD;
            cfg_reg.pwm_step        <= RST_PWM_STEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance the state only on an accepted item; hold otherwise.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.tick_count   <= '0;
            state_reg.report_count <= '0;
            state_reg.mode         <= MODE_REGULATE;
            state_reg.duty         <= '0;
            state_reg.angle        <= '0;
            state_reg.stored_mv    <= '0;
            state_reg.stored_temp  <= '0;
            state_reg.scan_active  <= 1'b0;
            state_reg.scan_angle   <= '0;
            state_reg.best_mv      <= '0;
            state_reg.best_angle   <= '0;
            state_reg.cooling      <= 1'b0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register: fill on accept, drop once the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

endmodule

@@ tb/sv/solar_tracker_mode_controller_core_tb.sv @@
// Self-checking testbench for the solar tracker mode controller core.
`timescale 1ns / 1ps

module solar_tracker_mode_controller_core_tb;

    import stmc_pkg::*;

    // Cycles without any accepted item or taken result before the run is declared hung.
    localparam int HANG_LIMIT = 2000;

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PULSED
    } ready_style_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;

    // Sensor events waiting to be sent, and the status items the block owes us.
    in_item_t  sensor_events [$];
    out_item_t status_due [$];

    // Own copy of the tracker state and its settings.
    state_t trk;
    cfg_t   tcfg;

    out_item_t    want_status;
    int           mismatches  = 0;
    int           idle_cycles = 0;
    int           burst_left  = 1;
    int           gap_left    = 0;
    ready_style_t ready_style = READY_ALWAYS;
    int           style_left  = 0;

    solar_tracker_mode_controller_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #4 aclk = ~aclk;

    // Advance the tracker by one sensor event and return the status it reports.
    task automatic advance_tracker(input in_item_t ev, output out_item_t res);
        logic hot;
        logic report_due;
        logic search_due;
        int   lo_mv;
        int   hi_mv;
        int   duty_up;
        res = '0;
        if (ev.kind == 1'b0) begin
            // Ticks change no state while the panel cools down.
            if (!trk.cooling) begin
                trk.tick_count   = trk.tick_count + 12'd1;
                trk.report_count = trk.report_count + 12'd1;
                report_due = (trk.report_count >= tcfg.report_period);
                if (report_due) begin
                    trk.report_count = '0;
                end
                search_due = (trk.tick_count > tcfg.search_period);
                if (search_due) begin
                    trk.tick_count   = '0;
                    trk.report_count = '0;
                end
                // A running scan keeps its mode; a search request beats a report.
                if (!trk.scan_active) begin
                    if (search_due) begin
                        trk.mode = MODE_SCAN;
                    end else if (report_due) begin
                        trk.mode = MODE_REPORT;
                    end
                end
            end
        end else begin
            hot = (ev.temp_c > tcfg.overheat_temp);
            trk.stored_temp = ev.temp_c;
            if (trk.cooling || trk.mode == MODE_HOT) begin
                if (hot && trk.cooling) begin
                    res.overheat_alarm = 1'b1;
                end else if (hot) begin
                    trk.cooling        = 1'b1;
                    res.overheat_alarm = 1'b1;
                end else begin
                    // Cooled off: go look for the sun again.
                    trk.cooling = 1'b0;
                    trk.mode    = MODE_SCAN;
                end
            end else if (hot) begin
                // Turn the panel away and abandon any scan in progress.
                trk.angle          = (trk.angle > FLIP_LIMIT) ? 8'd0 : FAR_ANGLE;
                trk.scan_active    = 1'b0;
                trk.cooling        = 1'b1;
                trk.mode           = MODE_HOT;
                res.overheat_alarm = 1'b1;
            end else if (trk.mode == MODE_REPORT) begin
                res.report_valid = 1'b1;
                res.report_mv    = trk.stored_mv;
                res.report_temp  = trk.stored_temp;
                trk.mode         = MODE_REGULATE;
            end else if (trk.mode == MODE_SCAN) begin
                if (!trk.scan_active) begin
                    // Start of scan: motor off, servo home, this reading is discarded.
                    trk.duty        = '0;
                    trk.scan_active = 1'b1;
                    trk.scan_angle  = '0;
                    trk.best_mv     = '0;
                    trk.best_angle  = trk.angle;
                end else begin
                    if (ev.panel_mv > trk.best_mv) begin
                        trk.best_mv    = ev.panel_mv;
                        trk.best_angle = trk.scan_angle;
                    end
                    trk.scan_angle = trk.scan_angle + SCAN_STEP;
                    if (trk.scan_angle >= SCAN_END) begin
                        trk.scan_active = 1'b0;
                        trk.scan_angle  = '0;
                        trk.angle       = trk.best_angle;
                        trk.mode        = MODE_REGULATE;
                    end
                end
            end else begin
                // Regulate: step the duty outside the dead band, saturating.
                lo_mv = int'(tcfg.target_mv) - int'(tcfg.hysteresis_band);
                hi_mv = int'(tcfg.target_mv) + int'(tcfg.hysteresis_band);
                trk.stored_mv = ev.panel_mv;
                if (int'(ev.panel_mv) < lo_mv && trk.duty > 8'd0) begin
                    trk.duty = (trk.duty > tcfg.pwm_step) ? trk.duty - tcfg.pwm_step : 8'd0;
                end else if (int'(ev.panel_mv) > hi_mv && trk.duty < DUTY_MAX) begin
                    duty_up = int'(trk.duty) + int'(tcfg.pwm_step);
                    if (duty_up > int'(DUTY_MAX)) begin
                        duty_up = int'(DUTY_MAX);
                    end
                    trk.duty = duty_up[7:0];
                end
            end
        end
        res.mode        = trk.mode;
        res.servo_angle = trk.scan_active ? trk.scan_angle : trk.angle;
        res.pwm_duty    = trk.duty;
    endtask

    task automatic check_field(input string fname, input logic [13:0] want_v,
                               input logic [13:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, fname, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic add_item(input logic kind, input logic [13:0] mv, input logic [7:0] temp);
        in_item_t ev;
        ev.kind     = kind;
        ev.panel_mv = mv;
        ev.temp_c   = temp;
        sensor_events.push_back(ev);
    endtask

    // Favor the extremes and the dead band edges; zero_pct biases toward a dark panel.
    function automatic logic [13:0] pick_mv(input int zero_pct);
        int v;
        if (int'($urandom_range(0, 99)) < zero_pct) begin
            return 14'd0;
        end
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 10000;
            2, 3: v = int'(tcfg.target_mv) + int'(tcfg.hysteresis_band)
                      + int'($urandom_range(0, 2)) - 1;
            4: v = int'(tcfg.target_mv) - int'(tcfg.hysteresis_band)
                   + int'($urandom_range(0, 2)) - 1;
            default: v = int'($urandom_range(0, 10000));
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > 10000) begin
            v = 10000;
        end
        return v[13:0];
    endfunction

    function automatic logic [7:0] cool_temp();
        return 8'($urandom_range(0, tcfg.overheat_temp));
    endfunction

    function automatic logic [7:0] hot_temp();
        return 8'($urandom_range(int'(tcfg.overheat_temp) + 1, 255));
    endfunction

    // Queue a random stretch: ticks, regulated readings, and overheat episodes
    // that run hot for a while and then cool down into a scan.
    task automatic queue_phase(input int n, input int zero_pct);
        int left;
        int r;
        int k;
        left = n;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                add_item(1'b0, 14'($urandom_range(0, 10000)), 8'($urandom_range(0, 255)));
                left--;
            end else if (r < 46 && tcfg.overheat_temp != 8'd255) begin
                add_item(1'b1, pick_mv(zero_pct), hot_temp());
                k = $urandom_range(0, 3);
                repeat (k) add_item(1'($urandom_range(0, 1)), pick_mv(zero_pct), hot_temp());
                add_item(1'b1, pick_mv(zero_pct), cool_temp());
                left -= k + 2;
            end else begin
                add_item(1'b1, pick_mv(zero_pct), cool_temp());
                left--;
            end
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Write every register; only called while the block is idle.
    task automatic apply_settings(input logic [7:0] ot, input logic [13:0] target,
                                  input logic [10:0] band, input logic [11:0] rp,
                                  input logic [11:0] sp, input logic [6:0] step);
        write_reg(CFG_OVERHEAT_TEMP, 14'(ot));
        write_reg(CFG_TARGET_MV, target);
        write_reg(CFG_HYSTERESIS_BAND, 14'(band));
        write_reg(CFG_REPORT_PERIOD, 14'(rp));
        write_reg(CFG_SEARCH_PERIOD, 14'(sp));
        write_reg(CFG_PWM_STEP, 14'(step));
        @(posedge aclk);
        cfg_we <= 1'b0;
        tcfg.overheat_temp   = ot;
        tcfg.target_mv       = target;
        tcfg.hysteresis_band = band;
        tcfg.report_period   = rp;
        tcfg.search_period   = sp;
        tcfg.pwm_step        = step;
    endtask

    // Hold until every queued event is sent and every status item is back.
    task automatic wait_drained();
        while (sensor_events.size() != 0 || s_valid || status_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Sender: bursts of random length separated by random gaps, gap zero being common.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0 || sensor_events.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                s_valid <= 1'b0;
            end else begin
                s_data  <= sensor_events.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24)
                                                              : $urandom_range(0, 3);
                end
            end
        end
    end

    // Receiver: pick a new stall style whenever the current one runs out.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                ready_style = ready_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(16, 96);
            end
            style_left--;
            case (ready_style)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:      m_ready <= (style_left % 12 == 0);
            endcase
        end
    end

    // Check results first: a result taken at this edge belongs to an earlier item.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    $display("%0t: status mismatch: expected none, actual %p", $time, m_data);
                    mismatches++;
                end else begin
                    want_status = status_due.pop_front();
                    check_field("mode", 14'(want_status.mode), 14'(m_data.mode));
                    check_field("servo_angle", 14'(want_status.servo_angle),
                                14'(m_data.servo_angle));
                    check_field("pwm_duty", 14'(want_status.pwm_duty), 14'(m_data.pwm_duty));
                    check_field("report_valid", 14'(want_status.report_valid),
                                14'(m_data.report_valid));
                    check_field("report_mv", want_status.report_mv, m_data.report_mv);
                    check_field("report_temp", 14'(want_status.report_temp),
                                14'(m_data.report_temp));
                    check_field("overheat_alarm", 14'(want_status.overheat_alarm),
                                14'(m_data.overheat_alarm));
                end
            end
            if (s_valid && s_ready) begin
                advance_tracker(s_data, want_status);
                status_due.push_back(want_status);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == HANG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int scan_mv [12];
        int dark_pct;
        trk  = '0;
        tcfg = '{RST_OVERHEAT_TEMP, RST_TARGET_MV, RST_HYSTERESIS_BAND,
                 RST_REPORT_PERIOD, RST_SEARCH_PERIOD, RST_PWM_STEP};
        scan_mv = '{100, 0, 7000, 7000, 10000, 50, 9999, 3, 4000, 10000, 1, 0};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: short report period, no timed search, pwm step of 64.
        apply_settings(8'd60, 14'd5000, 11'd200, 12'd3, 12'd4095, 7'd64);
        // Drive duty up to the ceiling, then down, hold on the lower band edge, then step up past the upper one.
        repeat (4) add_item(1'b1, 14'd10000, 8'd0);
        add_item(1'b1, 14'd0, 8'd60);
        add_item(1'b1, 14'd4800, 8'd20);
        add_item(1'b1, 14'd5201, 8'd20);
        // Three ticks raise a report request; the next reading returns the report.
        repeat (3) add_item(1'b0, 14'd0, 8'd0);
        add_item(1'b1, 14'd9999, 8'd33);
        // Overheat, a tick while cooling, still hot, then cool into a scan.
        add_item(1'b1, 14'd8191, 8'd61);
        add_item(1'b0, 14'd16383, 8'd255);
        add_item(1'b1, 14'd1, 8'd255);
        add_item(1'b1, 14'd2, 8'd0);
        add_item(1'b1, 14'd3000, 8'd25);
        // Twelve scan samples with a tick mixed in; equal readings do not move the best.
        foreach (scan_mv[i]) begin
            if (i == 3) begin
                add_item(1'b0, 14'd0, 8'd0);
            end
            add_item(1'b1, 14'(scan_mv[i]), 8'd30);
        end
        wait_drained();

        // Random phases: minimum settings, maximum settings, report on every tick
        // with a dark panel, then assorted settings.
        for (int p = 0; p < 10; p++) begin
            dark_pct = 5;
            case (p)
                0: apply_settings(8'd0, 14'd0, 11'd0, 12'd1, 12'd1, 7'd1);
                1: apply_settings(8'd255, 14'd10000, 11'd2000, 12'd4095, 12'd4095, 7'd64);
                2: begin
                    dark_pct = 90;
                    apply_settings(8'($urandom_range(30, 120)), 14'($urandom_range(0, 10000)),
                                   11'($urandom_range(0, 2000)), 12'd0,
                                   12'($urandom_range(1, 40)), 7'($urandom_range(1, 64)));
                end
                default: apply_settings(8'($urandom_range(20, 200)),
                                        14'($urandom_range(0, 10000)),
                                        11'($urandom_range(0, 2000)),
                                        ($urandom_range(0, 4) == 0) ?
                                            12'($urandom_range(1, 4095)) :
                                            12'($urandom_range(1, 12)),
                                        ($urandom_range(0, 4) == 0) ?
                                            12'($urandom_range(1, 4095)) :
                                            12'($urandom_range(1, 60)),
                                        7'($urandom_range(1, 64)));
            endcase
            queue_phase(125, dark_pct);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
